/* rtl/core/ale_pkg.sv */
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and codes for the array list engine: operation codes, status
// codes, the control word broadcast to the cell row and the response beat.
// ----------------------------------------------------------------------------
package ale_pkg;

    localparam int FUNC_W = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 2;

    localparam logic [FUNC_W-1:0] FN_INSERT   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LOCATE   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RETRIEVE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd4;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_DELETE,
        CMD_LOAD,
        CMD_SHIFT
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd                 cmd;
        logic [POS_W-1:0]          pos;
        logic signed [DATA_W-1:0]  value;
    } t_cell_ctl;

    typedef struct packed {
        logic                      match;
        logic signed [DATA_W-1:0]  data;
    } t_lane;

    typedef struct packed {
        logic signed [DATA_W-1:0]  read_value;
        logic [POS_W-1:0]          found_pos;
        t_status                   status;
        logic [POS_W-1:0]          entry_count;
    } t_rsp;

endpackage

/* rtl/core/ale_if.sv */
// ----------------------------------------------------------------------------
// ale_if
// Valid/ready channels of the array list engine: request and response.
// ----------------------------------------------------------------------------
interface ale_req_if;
    logic                                valid;
    logic                                ready;
    logic [ale_pkg::FUNC_W-1:0]          func;
    logic signed [ale_pkg::DATA_W-1:0]   item_value;
    logic [ale_pkg::POS_W-1:0]           item_pos;

    modport source (output valid, func, item_value, item_pos, input ready);
    modport sink   (input valid, func, item_value, item_pos, output ready);
endinterface

interface ale_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [ale_pkg::DATA_W-1:0]   read_value;
    logic [ale_pkg::POS_W-1:0]           found_pos;
    logic [ale_pkg::STAT_W-1:0]          status;
    logic [ale_pkg::POS_W-1:0]           entry_count;

    modport source (output valid, read_value, found_pos, status, entry_count, input ready);
    modport sink   (input valid, read_value, found_pos, status, entry_count, output ready);
endinterface

/* rtl/core/ale_cell.sv */
// ----------------------------------------------------------------------------
// ale_cell
// One list slot. Holds an entry, shifts it up or down with its neighbors on
// insert and delete, and carries a scan lane toward slot zero.
// ----------------------------------------------------------------------------
module ale_cell #(
    parameter int CAPACITY = 64,
    parameter int IDX      = 0
) (
    input  logic                              i_clk,
    input  ale_pkg::t_cell_ctl                i_ctl,
    input  logic signed [ale_pkg::DATA_W-1:0] i_prev_entry,
    input  logic signed [ale_pkg::DATA_W-1:0] i_next_entry,
    input  ale_pkg::t_lane                    i_next_lane,
    output logic signed [ale_pkg::DATA_W-1:0] o_entry,
    output ale_pkg::t_lane                    o_lane
);

    localparam int IW = ($clog2(CAPACITY) > ale_pkg::POS_W) ? $clog2(CAPACITY)
                                                            : ale_pkg::POS_W;
    localparam logic [IW-1:0] IDX_V = IW'(IDX);

    logic signed [ale_pkg::DATA_W-1:0] r_entry;
    ale_pkg::t_lane                    r_lane;
    logic [IW-1:0]                     pos_w;

    assign pos_w = IW'(i_ctl.pos);

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            ale_pkg::CMD_INSERT: begin
                if (IDX_V > pos_w) begin
                    r_entry <= i_prev_entry;
                end else if (IDX_V == pos_w) begin
                    r_entry <= i_ctl.value;
                end
            end
            ale_pkg::CMD_DELETE: begin
                if (IDX_V >= pos_w) begin
                    r_entry <= i_next_entry;
                end
            end
            ale_pkg::CMD_LOAD: begin
                r_lane.match <= (r_entry == i_ctl.value);
                r_lane.data  <= r_entry;
            end
            ale_pkg::CMD_SHIFT: begin
                r_lane <= i_next_lane;
            end
            default: begin
            end
        endcase
    end

    assign o_entry = r_entry;
    assign o_lane  = r_lane;

endmodule

/* rtl/core/array_list_engine_core.sv */
// ----------------------------------------------------------------------------
// array_list_engine_core
// Ordered list of signed 32-bit values kept in a row of cells, with insert,
// delete, locate, retrieve and clear operations.
// ----------------------------------------------------------------------------
// i_req carries one request beat (func, item_value, item_pos); o_rsp carries
// one response beat per request (read_value, found_pos, status, entry_count).
// One request is in flight at a time; i_req.ready is high only while idle.
// Insert, delete, clear, range errors and other codes go straight to the
// response stage; locate and retrieve first scan the lane, locate until a hit
// or the list end, retrieve until position p. An empty locate is a miss.
// The scan lane shifts one slot per cycle toward cell zero, where it is checked.
// A stalled o_rsp holds one beat in the output register and one in a holding
// register; i_req stays closed until the holding register drains.
// Reset empties the list, drops pending responses and holds i_req.ready low;
// entry contents are not cleared.
// ----------------------------------------------------------------------------
module array_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ale_req_if.sink   i_req,
    ale_rsp_if.source o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = $clog2(CAPACITY);
    localparam int W  = (CW > ale_pkg::POS_W) ? CW : ale_pkg::POS_W;
    localparam int PW = ale_pkg::POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state                        r_state;
    logic [CW-1:0]                 r_count;
    logic [KW-1:0]                 r_k;
    logic [ale_pkg::FUNC_W-1:0]    r_op;
    logic [PW-1:0]                 r_pos;
    ale_pkg::t_rsp                 r_res;
    ale_pkg::t_rsp                 r_out;
    logic                          r_out_valid;

    t_state                        n_state;
    logic [CW-1:0]                 n_count;
    logic [KW-1:0]                 n_k;
    logic [ale_pkg::FUNC_W-1:0]    n_op;
    logic [PW-1:0]                 n_pos;
    ale_pkg::t_rsp                 n_res;
    ale_pkg::t_rsp                 n_out;
    logic                          n_out_valid;

    ale_pkg::t_cell_ctl                 cell_ctl;
    logic signed [ale_pkg::DATA_W-1:0]  entries [CAPACITY];
    ale_pkg::t_lane                     lanes   [CAPACITY];

    logic          acc;
    logic [W-1:0]  pos_w;
    logic [W-1:0]  cnt_w;
    logic          ins_range;
    logic          full;
    logic          pos_bad;

    assign i_req.ready = i_rst_n && (r_state == S_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign pos_w       = W'(i_req.item_pos);
    assign cnt_w       = W'(r_count);
    assign ins_range   = pos_w > cnt_w;
    assign full        = r_count == CW'(CAPACITY);
    assign pos_bad     = pos_w >= cnt_w;

    always_comb begin
        cell_ctl.cmd   = ale_pkg::CMD_HOLD;
        cell_ctl.pos   = i_req.item_pos;
        cell_ctl.value = i_req.item_value;
        if (acc) begin
            case (i_req.func) inside
                ale_pkg::FN_INSERT: begin
                    if (!ins_range && !full) begin
                        cell_ctl.cmd = ale_pkg::CMD_INSERT;
                    end
                end
                ale_pkg::FN_DELETE: begin
                    if (!pos_bad) begin
                        cell_ctl.cmd = ale_pkg::CMD_DELETE;
                    end
                end
                ale_pkg::FN_LOCATE, ale_pkg::FN_RETRIEVE: begin
                    cell_ctl.cmd = ale_pkg::CMD_LOAD;
                end
                default: begin
                end
            endcase
        end else if (r_state == S_SCAN) begin
            cell_ctl.cmd = ale_pkg::CMD_SHIFT;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [ale_pkg::DATA_W-1:0] prev_entry;
        logic signed [ale_pkg::DATA_W-1:0] next_entry;
        ale_pkg::t_lane                    next_lane;

        if (g == 0) begin : g_first
            assign prev_entry = '0;
        end else begin : g_mid_lo
            assign prev_entry = entries[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_entry = entries[g];
            assign next_lane  = '0;
        end else begin : g_mid_hi
            assign next_entry = entries[g+1];
            assign next_lane  = lanes[g+1];
        end

        ale_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_prev_entry (prev_entry),
            .i_next_entry (next_entry),
            .i_next_lane  (next_lane),
            .o_entry      (entries[g]),
            .o_lane       (lanes[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_k         = r_k;
        n_op        = r_op;
        n_pos       = r_pos;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_op              = i_req.func;
                    n_pos             = i_req.item_pos;
                    n_k               = '0;
                    n_res.read_value  = '0;
                    n_res.found_pos   = '0;
                    n_res.status      = ale_pkg::ST_OK;
                    n_res.entry_count = PW'(r_count);
                    n_state           = S_FIN;
                    unique case (i_req.func)
                        ale_pkg::FN_INSERT: begin
                            if (ins_range) begin
                                n_res.status = ale_pkg::ST_RANGE;
                            end else if (full) begin
                                n_res.status = ale_pkg::ST_FULL;
                            end else begin
                                n_count           = r_count + CW'(1);
                                n_res.entry_count = PW'(r_count + CW'(1));
                            end
                        end
                        ale_pkg::FN_DELETE: begin
                            if (pos_bad) begin
                                n_res.status = ale_pkg::ST_RANGE;
                            end else begin
                                n_count           = r_count - CW'(1);
                                n_res.entry_count = PW'(r_count - CW'(1));
                            end
                        end
                        ale_pkg::FN_LOCATE: begin
                            if (r_count == '0) begin
                                n_res.status    = ale_pkg::ST_MISS;
                                n_res.found_pos = PW'(1);
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        ale_pkg::FN_RETRIEVE: begin
                            if (pos_bad) begin
                                n_res.status = ale_pkg::ST_RANGE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        ale_pkg::FN_CLEAR: begin
                            n_count           = '0;
                            n_res.entry_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_op == ale_pkg::FN_LOCATE) begin
                    if (lanes[0].match) begin
                        n_res.found_pos = PW'(r_k);
                        n_state         = S_FIN;
                    end else if (CW'(r_k) + CW'(1) == r_count) begin
                        n_res.status    = ale_pkg::ST_MISS;
                        n_res.found_pos = PW'(r_count + CW'(1));
                        n_state         = S_FIN;
                    end else begin
                        n_k = r_k + KW'(1);
                    end
                end else begin
                    if (W'(r_k) == W'(r_pos)) begin
                        n_res.read_value = lanes[0].data;
                        n_state          = S_FIN;
                    end else begin
                        n_k = r_k + KW'(1);
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_k   <= n_k;
        r_op  <= n_op;
        r_pos <= n_pos;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_out.read_value;
    assign o_rsp.found_pos   = r_out.found_pos;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.entry_count = r_out.entry_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list count above capacity");

    a_scan_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_k) < r_count))
        else $error("scan step beyond list end");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_state != S_IDLE))
        else $error("request beat taken without leaving idle");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for array_list_engine_core. Requests go through a
// valid/ready source with random gaps. A shadow copy of the list predicts
// every response beat. A checker compares each accepted response with the
// oldest prediction. The receiver stalls at random and holds off once for a
// long stretch so that the engine backs up into its request port.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FW = ale_pkg::FUNC_W;
    localparam int DW = ale_pkg::DATA_W;
    localparam int PW = ale_pkg::POS_W;

    localparam int LIST_CAP    = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 100;

    localparam logic [FW-1:0] FN_RSVD_A = 3'd5;
    localparam logic [FW-1:0] FN_RSVD_B = 3'd6;
    localparam logic [FW-1:0] FN_RSVD_C = 3'd7;

    localparam logic signed [DW-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DW-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    bit   rst_done;

    ale_req_if req_bus ();
    ale_rsp_if rsp_bus ();

    array_list_engine_core #(
        .CAPACITY (LIST_CAP)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // shadow list
    logic signed [DW-1:0] list_vals [LIST_CAP];
    int                   list_len;

    ale_pkg::t_rsp pending_rsp [$];
    int            n_errors;
    bit            tx_gaps_on;
    bit            rx_gaps_on;
    bit            hold_pending;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic ale_pkg::t_rsp list_apply(input logic [FW-1:0] fn,
                                                 input logic signed [DW-1:0] v,
                                                 input logic [PW-1:0] p);
        ale_pkg::t_rsp r;
        int            k;
        bit            hit;
        r        = '0;
        r.status = ale_pkg::ST_OK;
        case (fn)
            ale_pkg::FN_INSERT: begin
                if (p > list_len) begin
                    r.status = ale_pkg::ST_RANGE;
                end else if (list_len >= LIST_CAP) begin
                    r.status = ale_pkg::ST_FULL;
                end else begin
                    for (k = list_len; k > p; k--) list_vals[k] = list_vals[k-1];
                    list_vals[p] = v;
                    list_len++;
                end
            end
            ale_pkg::FN_DELETE: begin
                if (p >= list_len) begin
                    r.status = ale_pkg::ST_RANGE;
                end else begin
                    for (k = p; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
                    list_len--;
                end
            end
            ale_pkg::FN_LOCATE: begin
                r.status    = ale_pkg::ST_MISS;
                r.found_pos = PW'(list_len + 1);
                hit         = 1'b0;
                for (k = 0; k < list_len && !hit; k++) begin
                    if (list_vals[k] == v) begin
                        hit         = 1'b1;
                        r.found_pos = PW'(k);
                        r.status    = ale_pkg::ST_OK;
                    end
                end
            end
            ale_pkg::FN_RETRIEVE: begin
                if (p >= list_len) r.status = ale_pkg::ST_RANGE;
                else r.read_value = list_vals[p];
            end
            ale_pkg::FN_CLEAR: begin
                list_len = 0;
            end
            default: ;
        endcase
        r.entry_count = PW'(list_len);
        return r;
    endfunction

    function automatic logic signed [DW-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3:    return DW'($signed($urandom_range(0, 6)) - 3);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [DW-1:0] pick_key();
        if (list_len > 0 && $urandom_range(0, 99) < 60)
            return list_vals[$urandom_range(0, list_len - 1)];
        return rand_value();
    endfunction

    function automatic logic [PW-1:0] rand_pos(input logic [FW-1:0] fn);
        if (fn == ale_pkg::FN_INSERT) begin
            if ($urandom_range(0, 99) < 85) return PW'($urandom_range(0, list_len));
        end else if (list_len > 0 && $urandom_range(0, 99) < 85) begin
            return PW'($urandom_range(0, list_len - 1));
        end
        return PW'($urandom_range(0, LIST_CAP));
    endfunction

    function automatic logic [FW-1:0] pick_func(input int w_ins, input int w_del,
                                                input int w_loc, input int w_clr);
        int r;
        r = $urandom_range(0, 99);
        if (r == 99) begin
            case ($urandom_range(0, 2))
                0:       return FN_RSVD_A;
                1:       return FN_RSVD_B;
                default: return FN_RSVD_C;
            endcase
        end
        if (r < w_ins) return ale_pkg::FN_INSERT;
        if (r < w_ins + w_del) return ale_pkg::FN_DELETE;
        if (r < w_ins + w_del + w_loc) return ale_pkg::FN_LOCATE;
        if (r < w_ins + w_del + w_loc + w_clr) return ale_pkg::FN_CLEAR;
        return ale_pkg::FN_RETRIEVE;
    endfunction

    // one request beat; the expected response is queued at acceptance
    task automatic send_req(input logic [FW-1:0] fn,
                            input logic signed [DW-1:0] v,
                            input logic [PW-1:0] p);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.func       <= fn;
        req_bus.item_value <= v;
        req_bus.item_pos   <= p;
        do @(posedge i_clk); while (!(req_bus.valid && req_bus.ready));
        pending_rsp.push_back(list_apply(fn, v, p));
    endtask

    task automatic run_mix(input int n, input int w_ins, input int w_del,
                           input int w_loc, input int w_clr);
        logic [FW-1:0]        fn;
        logic signed [DW-1:0] v;
        for (int i = 0; i < n; i++) begin
            fn = pick_func(w_ins, w_del, w_loc, w_clr);
            v  = (fn == ale_pkg::FN_LOCATE) ? pick_key() : rand_value();
            send_req(fn, v, rand_pos(fn));
        end
    endtask

    task automatic test_corner_cases();
        send_req(ale_pkg::FN_RETRIEVE, 0, 0);
        send_req(ale_pkg::FN_DELETE, 0, 0);
        send_req(ale_pkg::FN_LOCATE, 0, 0);
        send_req(ale_pkg::FN_INSERT, 5, 1);
        send_req(ale_pkg::FN_INSERT, VAL_MIN, 0);
        send_req(ale_pkg::FN_INSERT, VAL_MAX, 1);
        send_req(ale_pkg::FN_INSERT, -1, 0);
        send_req(ale_pkg::FN_INSERT, 0, 3);
        send_req(ale_pkg::FN_INSERT, 7, 2);
        send_req(ale_pkg::FN_INSERT, 9, 6);
        send_req(ale_pkg::FN_INSERT, 9, 64);
        send_req(ale_pkg::FN_INSERT, -1, 4);
        send_req(ale_pkg::FN_RETRIEVE, 0, 0);
        send_req(ale_pkg::FN_RETRIEVE, 0, 5);
        send_req(ale_pkg::FN_RETRIEVE, 0, 6);
        send_req(ale_pkg::FN_LOCATE, VAL_MAX, 0);
        send_req(ale_pkg::FN_LOCATE, -1, 0);
        send_req(ale_pkg::FN_LOCATE, 12345, 0);
        send_req(ale_pkg::FN_DELETE, 0, 0);
        send_req(ale_pkg::FN_DELETE, 0, 4);
        send_req(ale_pkg::FN_DELETE, 0, 1);
        send_req(FN_RSVD_A, VAL_MAX, 64);
        send_req(FN_RSVD_B, VAL_MIN, 0);
        send_req(FN_RSVD_C, -1, 127);
        send_req(ale_pkg::FN_CLEAR, 0, 0);
        send_req(ale_pkg::FN_RETRIEVE, 0, 0);
    endtask

    task automatic test_fill_to_capacity();
        while (list_len < LIST_CAP)
            send_req(ale_pkg::FN_INSERT, rand_value(), PW'($urandom_range(0, list_len)));
        send_req(ale_pkg::FN_INSERT, 1, 0);
        send_req(ale_pkg::FN_INSERT, 1, 64);
        send_req(ale_pkg::FN_RETRIEVE, 0, 63);
        send_req(ale_pkg::FN_RETRIEVE, 0, 64);
        send_req(ale_pkg::FN_LOCATE, list_vals[LIST_CAP-1], 0);
        send_req(ale_pkg::FN_LOCATE, 32'sh5A5A_1234, 0);
        while (list_len > 0)
            send_req(ale_pkg::FN_DELETE, 0, PW'($urandom_range(0, list_len - 1)));
        send_req(ale_pkg::FN_DELETE, 0, 0);
    endtask

    task automatic test_mixed_traffic();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_mix(150, 60, 10, 15, 0);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        run_mix(200, 30, 25, 25, 1);
        run_mix(300, 55, 15, 15, 0);
        rx_gaps_on = 1'b0;
        run_mix(300, 35, 30, 20, 0);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b1;
        run_mix(200, 20, 45, 15, 0);
        tx_gaps_on = 1'b1;
        run_mix(250, 40, 20, 20, 2);
    endtask

    task automatic test_output_stall();
        tx_gaps_on   = 1'b0;
        hold_pending = 1'b1;
        run_mix(40, 40, 20, 20, 0);
        tx_gaps_on   = 1'b1;
    endtask

    // response side: random stalls, one long hold-off on request
    initial begin
        int gap;
        rsp_bus.ready <= 1'b0;
        while (!rst_done) @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_pending = 1'b0;
            end else begin
                gap = rx_gaps_on ? $urandom_range(0, 13) : 0;
                if (gap > 0) begin
                    rsp_bus.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_bus.valid && rsp_bus.ready));
        end
    end

    task automatic flag_field(input string what, input logic [DW-1:0] want,
                              input logic [DW-1:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t: %s mismatch: expected 'h%0h, actual 'h%0h",
                     $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        ale_pkg::t_rsp want;
        if (rst_done && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_rsp.size() == 0) begin
                n_errors++;
                $display("%0t: response beat with nothing expected: %s'h%0h",
                         $time, "expected none, actual ", rsp_bus.read_value);
            end else begin
                want = pending_rsp.pop_front();
                flag_field("read_value", want.read_value, rsp_bus.read_value);
                flag_field("found_pos", DW'(want.found_pos), DW'(rsp_bus.found_pos));
                flag_field("status", DW'(want.status), DW'(rsp_bus.status));
                flag_field("entry_count", DW'(want.entry_count),
                           DW'(rsp_bus.entry_count));
            end
        end
    end

    // watchdog: cycles without any beat on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!rst_done || (req_bus.valid && req_bus.ready) ||
                (rsp_bus.valid && rsp_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        n_errors           = 0;
        list_len           = 0;
        tx_gaps_on         = 1'b1;
        rx_gaps_on         = 1'b1;
        hold_pending       = 1'b0;
        rst_done           <= 1'b0;
        foreach (list_vals[k]) list_vals[k] = '0;
        i_rst_n            <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.func       <= ale_pkg::FN_INSERT;
        req_bus.item_value <= '0;
        req_bus.item_pos   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n            <= 1'b1;
        rst_done           <= 1'b1;

        test_corner_cases();
        test_fill_to_capacity();
        test_mixed_traffic();
        test_output_stall();
        test_fill_to_capacity();
        run_mix(100, 45, 20, 20, 1);

        req_bus.valid <= 1'b0;
        while (pending_rsp.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
